>>> sv/box_filter_image_downscaler_core_defines.svh
// ----------------------------------------------------------------------------
// Box filter downscaler: assertion macros
// Shorthand for clocked implication checks, disabled while the active-low reset is low.
// ----------------------------------------------------------------------------
`ifndef BOX_FILTER_IMAGE_DOWNSCALER_CORE_DEFINES_SVH
`define BOX_FILTER_IMAGE_DOWNSCALER_CORE_DEFINES_SVH

// same-cycle implication
`define BFID_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define BFID_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/bfid_pkg.sv
// ----------------------------------------------------------------------------
// Box filter downscaler package
// Shared widths, register indexes and defaults.
// ----------------------------------------------------------------------------
`default_nettype none

package bfid_pkg;

    localparam int MAX_SRC_DIM_DEF = 1024;
    localparam int MAX_DST_DIM_DEF = 64;

    localparam int SRC_REG_W  = 11;
    localparam int DST_REG_W  = 7;
    localparam int CFG_DATA_W = 11;
    localparam int CFG_IDX_W  = 3;

    localparam int PIX_W   = 24;
    localparam int CH_W    = 8;
    localparam int NUM_CH  = 3;
    localparam int COORD_W = 6;
    localparam int Q_STEPS = 8;

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_cfg_idx CFG_SRC_WIDTH  = 3'd0;
    localparam t_cfg_idx CFG_SRC_HEIGHT = 3'd1;
    localparam t_cfg_idx CFG_DST_WIDTH  = 3'd2;
    localparam t_cfg_idx CFG_DST_HEIGHT = 3'd3;

    localparam logic [SRC_REG_W-1:0] DEF_SRC = 11'd64;
    localparam logic [DST_REG_W-1:0] DEF_DST = 7'd32;

endpackage

`default_nettype wire

>>> sv/bfid_div.sv
// ----------------------------------------------------------------------------
// Box filter downscaler: area divider
// Three-lane restoring divider, one quotient bit per cycle, 8-bit quotients.
// ----------------------------------------------------------------------------
`default_nettype none

module bfid_div
    import bfid_pkg::*;
#(
    parameter int AREA_W = 22
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_start,
    input  wire logic [NUM_CH-1:0][AREA_W+CH_W-1:0]    i_sum,
    input  wire logic [AREA_W-1:0]                     i_area,
    output logic                                       o_done,
    output logic [NUM_CH-1:0][CH_W-1:0]                o_quot
);

    localparam int SUM_W = AREA_W + CH_W;
    localparam int KW    = $clog2(Q_STEPS);

    logic                          r_busy;
    logic                          r_done;
    logic [KW-1:0]                 r_k;
    logic [AREA_W-1:0]             r_area;
    logic [NUM_CH-1:0][SUM_W-1:0]  r_rem;
    logic [NUM_CH-1:0][CH_W-1:0]   r_quot;
    logic [SUM_W-1:0]              w_dsh;

    // divisor aligned to the current quotient bit
    always_comb begin
        w_dsh = SUM_W'(r_area) << r_k;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_k    <= KW'(Q_STEPS - 1);
                r_rem  <= i_sum;
                r_quot <= '0;
                r_area <= i_area;
            end else if (r_busy) begin
                for (int c = 0; c < NUM_CH; c++) begin
                    if (r_rem[c] >= w_dsh) begin
                        r_rem[c]       <= r_rem[c] - w_dsh;
                        r_quot[c][r_k] <= 1'b1;
                    end
                end
                if (r_k == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_k <= r_k - 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

`default_nettype wire

>>> sv/box_filter_image_downscaler_core.sv
// ----------------------------------------------------------------------------
// Box filter image downscaler core
// Area-average downscale of a raster RGB stream, per-column sums in memory.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake                  Payload
// pixel in  input      i_in_valid / o_in_stall    i_source_pixel
// pixel out output     o_out_valid / i_out_stall  o_out_pixel, o_out_col,
//                                                 o_out_row, o_frame_end
// config    input      i_cfg_we                   i_cfg_idx, i_cfg_data
//
// A pixel that closes no box goes through a sum memory read, then write back.
// A box-closing pixel goes through read, sum and area multiply, divider load,
// 8 divider steps, done, output load.
// Reset and any write to a size register restart the frame once the block is
// idle (valid bits cleared in that step); input is stalled until it is done.
// A full output register holds the block in its last step until it drains.
// ----------------------------------------------------------------------------
`default_nettype none
`include "box_filter_image_downscaler_core_defines.svh"

module box_filter_image_downscaler_core
    import bfid_pkg::*;
#(
    parameter int MAX_SRC_DIM = MAX_SRC_DIM_DEF,
    parameter int MAX_DST_DIM = MAX_DST_DIM_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    output logic                       o_in_stall,
    input  wire logic [PIX_W-1:0]      i_source_pixel,
    output logic                       o_out_valid,
    input  wire logic                  i_out_stall,
    output logic [PIX_W-1:0]           o_out_pixel,
    output logic [COORD_W-1:0]         o_out_col,
    output logic [COORD_W-1:0]         o_out_row,
    output logic                       o_frame_end,
    input  wire logic                  i_cfg_we,
    input  wire t_cfg_idx              i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int SDW    = $clog2(MAX_SRC_DIM + 1);
    localparam int DDW    = $clog2(MAX_DST_DIM + 1);
    localparam int AW     = $clog2(MAX_DST_DIM);
    localparam int AREA_W = 2 * SDW;
    localparam int SUM_W  = AREA_W + CH_W;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ACC,
        ST_DIV,
        ST_OUT
    } t_state;

    t_state                        r_state;
    logic                          r_restart;
    logic [SRC_REG_W-1:0]          r_src_w, r_src_h;
    logic [DST_REG_W-1:0]          r_dst_w, r_dst_h;

    logic [SDW-1:0]                sw, sh;
    logic [DDW-1:0]                dw, dh;
    logic [SDW-1:0]                dw_s, dh_s;

    // position state
    logic [SDW-1:0]                r_col, r_row;
    logic [AW-1:0]                 r_dx, r_dy;
    logic [SDW-1:0]                r_ce, r_re;   // band-end error terms, in [0, s)
    logic [SDW-1:0]                r_cw, r_rh;   // pixels already in current band

    // item in flight
    logic [PIX_W-1:0]              r_px;
    logic                          r_emit;
    logic                          r_fe;
    logic [AW-1:0]                 r_addr;
    logic [AW-1:0]                 r_oy;
    logic [SDW-1:0]                r_cwq, r_rhq;
    logic                          r_rvld;

    logic [NUM_CH*SUM_W-1:0]       mem [MAX_DST_DIM];
    logic [NUM_CH*SUM_W-1:0]       r_rd;
    logic [MAX_DST_DIM-1:0]        r_vld;

    logic [NUM_CH-1:0][SUM_W-1:0]  w_cur;
    logic [NUM_CH-1:0][SUM_W-1:0]  w_nsum;
    logic [NUM_CH-1:0][SUM_W-1:0]  r_sum;
    logic [AREA_W-1:0]             r_area;
    logic                          r_div_start;
    logic                          w_div_done;
    logic [NUM_CH-1:0][CH_W-1:0]   w_quot;

    logic                          r_out_valid;
    logic [PIX_W-1:0]              r_out_pixel;
    logic [COORD_W-1:0]            r_out_col, r_out_row;
    logic                          r_frame_end;

    logic                          in_acc;
    logic                          col_end, row_end, col_last, row_last;
    logic                          w_mem_we;

    // effective sizes
    always_comb begin
        if (r_src_w == '0)                       sw = SDW'(1);
        else if (int'(r_src_w) > MAX_SRC_DIM)    sw = SDW'(MAX_SRC_DIM);
        else                                     sw = SDW'(r_src_w);
        if (r_src_h == '0)                       sh = SDW'(1);
        else if (int'(r_src_h) > MAX_SRC_DIM)    sh = SDW'(MAX_SRC_DIM);
        else                                     sh = SDW'(r_src_h);

        if (r_dst_w == '0)                       dw = DDW'(1);
        else if (int'(r_dst_w) > MAX_DST_DIM)    dw = DDW'(MAX_DST_DIM);
        else                                     dw = DDW'(r_dst_w);
        if (int'(dw) > int'(sw))                 dw = DDW'(sw);
        if (r_dst_h == '0)                       dh = DDW'(1);
        else if (int'(r_dst_h) > MAX_DST_DIM)    dh = DDW'(MAX_DST_DIM);
        else                                     dh = DDW'(r_dst_h);
        if (int'(dh) > int'(sh))                 dh = DDW'(sh);

        dw_s = SDW'(dw);
        dh_s = SDW'(dh);
    end

    always_comb begin
        col_end  = r_ce < dw_s;
        row_end  = r_re < dh_s;
        col_last = ({1'b0, r_col} + 1'b1) == {1'b0, sw};
        row_last = ({1'b0, r_row} + 1'b1) == {1'b0, sh};
    end

    assign o_in_stall = (r_state != ST_IDLE) || r_restart;
    assign in_acc     = i_in_valid && !o_in_stall;

    // accumulate; entries not written since restart or since their box was emitted read as zero
    always_comb begin
        w_cur = r_rvld ? r_rd : '0;
        for (int c = 0; c < NUM_CH; c++) begin
            w_nsum[c] = w_cur[c] + SUM_W'(r_px[c*CH_W +: CH_W]);
        end
    end

    assign w_mem_we = (r_state == ST_ACC) && !r_emit;

    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            mem[r_addr] <= w_nsum;
        end
        if (in_acc) begin
            r_rd <= mem[r_dx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_restart   <= 1'b1;
            r_src_w     <= DEF_SRC;
            r_src_h     <= DEF_SRC;
            r_dst_w     <= DEF_DST;
            r_dst_h     <= DEF_DST;
            r_vld       <= '0;
            r_out_valid <= 1'b0;
            r_div_start <= 1'b0;
        end else begin
            r_div_start <= 1'b0;
            if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                ST_IDLE: begin
                    if (r_restart) begin
                        r_restart <= 1'b0;
                        r_vld     <= '0;
                        r_col     <= '0;
                        r_row     <= '0;
                        r_dx      <= '0;
                        r_dy      <= '0;
                        r_cw      <= '0;
                        r_rh      <= '0;
                        r_ce      <= sw - dw_s;
                        r_re      <= sh - dh_s;
                    end else if (i_in_valid) begin
                        r_px    <= i_source_pixel;
                        r_emit  <= col_end && row_end;
                        r_fe    <= col_last && row_last;
                        r_addr  <= r_dx;
                        r_oy    <= r_dy;
                        r_cwq   <= r_cw + 1'b1;
                        r_rhq   <= r_rh + 1'b1;
                        r_rvld  <= r_vld[r_dx];
                        r_state <= ST_ACC;

                        r_col <= r_col + 1'b1;
                        r_cw  <= col_end ? '0 : r_cw + 1'b1;
                        if (col_end) begin
                            r_dx <= r_dx + 1'b1;
                            r_ce <= SDW'({1'b0, r_ce} + {1'b0, sw} - {1'b0, dw_s});
                        end else begin
                            r_ce <= r_ce - dw_s;
                        end
                        if (col_last) begin
                            r_col <= '0;
                            r_dx  <= '0;
                            r_ce  <= sw - dw_s;
                            r_row <= r_row + 1'b1;
                            r_rh  <= row_end ? '0 : r_rh + 1'b1;
                            if (row_end) begin
                                r_dy <= r_dy + 1'b1;
                                r_re <= SDW'({1'b0, r_re} + {1'b0, sh} - {1'b0, dh_s});
                            end else begin
                                r_re <= r_re - dh_s;
                            end
                            if (row_last) begin
                                r_row <= '0;
                                r_dy  <= '0;
                                r_re  <= sh - dh_s;
                            end
                        end
                    end
                end
                ST_ACC: begin
                    if (r_emit) begin
                        r_vld[r_addr] <= 1'b0;
                        r_sum         <= w_nsum;
                        r_area        <= AREA_W'(r_cwq) * AREA_W'(r_rhq);
                        r_div_start   <= 1'b1;
                        r_state       <= ST_DIV;
                    end else begin
                        r_vld[r_addr] <= 1'b1;
                        r_state       <= ST_IDLE;
                    end
                end
                ST_DIV: begin
                    if (w_div_done) begin
                        r_state <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    if (!r_out_valid || !i_out_stall) begin
                        r_out_valid <= 1'b1;
                        r_out_pixel <= w_quot;
                        r_out_col   <= COORD_W'(r_addr);
                        r_out_row   <= COORD_W'(r_oy);
                        r_frame_end <= r_fe;
                        r_state     <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase

            // after the restart step so a write in the same cycle is not lost
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_SRC_WIDTH: begin
                        r_src_w   <= i_cfg_data[SRC_REG_W-1:0];
                        r_restart <= 1'b1;
                    end
                    CFG_SRC_HEIGHT: begin
                        r_src_h   <= i_cfg_data[SRC_REG_W-1:0];
                        r_restart <= 1'b1;
                    end
                    CFG_DST_WIDTH: begin
                        r_dst_w   <= i_cfg_data[DST_REG_W-1:0];
                        r_restart <= 1'b1;
                    end
                    CFG_DST_HEIGHT: begin
                        r_dst_h   <= i_cfg_data[DST_REG_W-1:0];
                        r_restart <= 1'b1;
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    bfid_div #(
        .AREA_W (AREA_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_div_start),
        .i_sum   (r_sum),
        .i_area  (r_area),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    assign o_out_valid = r_out_valid;
    assign o_out_pixel = r_out_pixel;
    assign o_out_col   = r_out_col;
    assign o_out_row   = r_out_row;
    assign o_frame_end = r_frame_end;

    `BFID_ASSERT_NEXT(a_acc_after_accept, i_clk, i_rst_n, in_acc, r_state == ST_ACC, "no accumulate step after transfer")
    `BFID_ASSERT_NEXT(a_restart_clears, i_clk, i_rst_n, r_restart && (r_state == ST_IDLE), r_vld == '0, "restart left valid bits set")
    `BFID_ASSERT_SAME(a_err_range, i_clk, i_rst_n, !r_restart, (r_ce < sw) && (r_re < sh), "band error term out of range")
    `BFID_ASSERT_SAME(a_done_in_div, i_clk, i_rst_n, w_div_done, r_state == ST_DIV, "divider finished outside divide state")

endmodule

`default_nettype wire
